// ===== rtl/core/rtc_pkg.sv =====
package rtc_pkg;

   localparam int MaxPoints  = 1024;
   localparam int RowW       = 10;
   localparam int CountW     = $clog2(MaxPoints + 2);
   localparam int CoordW     = 32;
   localparam int CoefW      = 64;
   localparam int FracW      = 24;
   localparam int TwoDtW     = 63;
   localparam int RatioW     = 32;
   localparam int CsrIndexW  = 1;
   localparam int CsrDataW   = 64;
   localparam int RecipShift = 48;
   localparam int QuoW       = RecipShift + 2;
   localparam int DivCycles  = QuoW / 2;
   localparam int DivCntW    = $clog2(DivCycles);
   localparam int HalfW      = CoefW / 2;
   localparam int ProdW      = 2 * CoefW;
   localparam int MulSteps   = 4;
   localparam int MulCntW    = $clog2(MulSteps + 1);

   localparam logic [CsrIndexW-1:0] CSR_TWO_DT = 1'd0;
   localparam logic [CsrIndexW-1:0] CSR_RATIO  = 1'd1;

   localparam logic signed [CoefW-1:0] COEF_MAX = {1'b0, {(CoefW-1){1'b1}}};
   localparam logic signed [CoefW-1:0] COEF_MIN = {1'b1, {(CoefW-1){1'b0}}};
   localparam logic signed [CoefW-1:0] ONE_Q24  = CoefW'(64'sd1 <<< FracW);

   typedef enum logic [7:0] {
      ST_IDLE      = 8'b0000_0001,
      ST_DIV_START = 8'b0000_0010,
      ST_DIV_RUN   = 8'b0000_0100,
      ST_DISPATCH  = 8'b0000_1000,
      ST_MUL_RUN   = 8'b0001_0000,
      ST_MUL_END   = 8'b0010_0000,
      ST_OUT_ROW   = 8'b0100_0000,
      ST_OUT_END   = 8'b1000_0000
   } state_type;

   typedef enum logic [3:0] {
      SEQ_LO, SEQ_UP, SEQ_C0, SEQ_C2, SEQ_SA, SEQ_MA, SEQ_C3, SEQ_C5, SEQ_SB, SEQ_MB,
      SEQ_DONE
   } seq_type;

   typedef enum logic [1:0] {
      DIV_SPAN, DIV_INNER, DIV_LEFT, DIV_RIGHT
   } div_sel_type;

   typedef struct packed {
      logic                    sat;
      logic signed [CoefW-1:0] value;
   } sat_val_type;

   typedef struct packed {
      logic [CoordW-1:0] rem;
      logic [QuoW-1:0]   quo;
   } div_type;

   typedef struct packed {
      logic            ovf;
      logic [RowW-1:0] row;
   } row_type;

   function automatic sat_val_type sat_add(input logic signed [CoefW-1:0] a,
                                           input logic signed [CoefW-1:0] b);
      sat_val_type r;
      r.value = a + b;
      r.sat   = 1'b0;
      if (!a[CoefW-1] && !b[CoefW-1] && r.value[CoefW-1]) begin
         r.sat   = 1'b1;
         r.value = COEF_MAX;
      end else if (a[CoefW-1] && b[CoefW-1] && !r.value[CoefW-1]) begin
         r.sat   = 1'b1;
         r.value = COEF_MIN;
      end
      return r;
   endfunction

   function automatic sat_val_type sat_neg(input logic signed [CoefW-1:0] a);
      sat_val_type r;
      if (a == COEF_MIN) begin
         r.sat   = 1'b1;
         r.value = COEF_MAX;
      end else begin
         r.sat   = 1'b0;
         r.value = -a;
      end
      return r;
   endfunction

   function automatic logic [CoefW-1:0] mag(input logic signed [CoefW-1:0] a);
      return a[CoefW-1] ? CoefW'(-a) : CoefW'(a);
   endfunction

   function automatic sat_val_type from_mag(input logic [CoefW-1:0] m, input logic neg);
      sat_val_type r;
      r.sat = 1'b0;
      if (neg) begin
         if (m > {1'b1, {(CoefW-1){1'b0}}}) begin
            r.sat   = 1'b1;
            r.value = COEF_MIN;
         end else begin
            r.value = CoefW'(0) - m;
         end
      end else begin
         if (m[CoefW-1]) begin
            r.sat   = 1'b1;
            r.value = COEF_MAX;
         end else begin
            r.value = m;
         end
      end
      return r;
   endfunction

   function automatic div_type div_step(input div_type s, input logic [CoordW-1:0] m);
      logic [CoordW:0] r1;
      div_type         o;
      r1 = {s.rem, s.quo[QuoW-1]};
      if (r1 >= {1'b0, m}) begin
         o.rem = CoordW'(r1 - {1'b0, m});
         o.quo = {s.quo[QuoW-2:0], 1'b1};
      end else begin
         o.rem = r1[CoordW-1:0];
         o.quo = {s.quo[QuoW-2:0], 1'b0};
      end
      return o;
   endfunction

   function automatic row_type row_clamp(input logic [CountW-1:0] r);
      row_type o;
      if (r > CountW'(MaxPoints - 1)) begin
         o.ovf = 1'b1;
         o.row = RowW'(MaxPoints - 1);
      end else begin
         o.ovf = 1'b0;
         o.row = RowW'(r);
      end
      return o;
   endfunction

endpackage

// ===== rtl/core/radial_tridiagonal_coefficients_core.sv =====
// Channel   Direction  Handshake              Payload
// req_      in         req_valid/req_ready    coordinate (Q8.24), final_point
// rsp_      out        rsp_valid/rsp_ready    row, lower/main/upper a and b (Q40.24),
//                                             saturated, last_row
// csr_      in         csr_valid/csr_ready    csr_index, csr_wdata
//
// Interior point: four reciprocals on the shared radix-4 divider, then four
// multiplies, each built from four 32x32 partial products.
// A point that yields only a boundary row, or no row, bypasses the divider.
// req_ready is high only when idle; a finished row waits in the rsp register
// while the next point is taken. Synchronous reset; csr always ready.
module radial_tridiagonal_coefficients_core
   import rtc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [CoordW-1:0]       req_coordinate,
   input  logic                    req_final_point,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [RowW-1:0]         rsp_row,
   output logic signed [CoefW-1:0] rsp_lower_a,
   output logic signed [CoefW-1:0] rsp_main_a,
   output logic signed [CoefW-1:0] rsp_upper_a,
   output logic signed [CoefW-1:0] rsp_lower_b,
   output logic signed [CoefW-1:0] rsp_main_b,
   output logic signed [CoefW-1:0] rsp_upper_b,
   output logic                    rsp_saturated,
   output logic                    rsp_last_row,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CsrIndexW-1:0]    csr_index,
   input  logic [CsrDataW-1:0]     csr_wdata
);

   state_type               state_ff, state_in;
   seq_type                 seq_ff, seq_in;
   div_sel_type             div_idx_ff, div_idx_in;
   logic [DivCntW-1:0]      div_cnt_ff, div_cnt_in;
   div_type                 div_ff, div_in;
   logic [CoordW-1:0]       div_m_ff, div_m_in;
   logic                    div_neg_ff, div_neg_in;
   logic [CoefW-1:0]        mul_a_ff, mul_a_in;
   logic [CoefW-1:0]        mul_b_ff, mul_b_in;
   logic                    mul_neg_ff, mul_neg_in;
   logic [MulCntW-1:0]      mul_cnt_ff, mul_cnt_in;
   logic [CoefW-1:0]        prod_ff, prod_in;
   logic [1:0]              pp_sh_ff, pp_sh_in;
   logic [ProdW-1:0]        acc_ff, acc_in;
   logic signed [CoefW-1:0] rs_ff, rs_in, rx_ff, rx_in, r2a_ff, r2a_in, r2b_ff, r2b_in;
   logic signed [CoefW-1:0] lo_ff, lo_in, up_ff, up_in, tmp_ff, tmp_in;
   logic signed [CoefW-1:0] c0_ff, c0_in, c2_ff, c2_in, ma_ff, ma_in;
   logic signed [CoefW-1:0] c3_ff, c3_in, c5_ff, c5_in, mb_ff, mb_in;
   logic                    sat_ff, sat_in;
   logic                    start_ff, start_in;
   logic [CoordW-1:0]       cur_ff, cur_in;
   logic                    fin_ff, fin_in;
   logic [CoordW-1:0]       prev_ff, prev_in, older_ff, older_in;
   logic [CountW-1:0]       points_ff, points_in;
   logic [TwoDtW-1:0]       two_dt_ff, two_dt_in;
   logic [RatioW-1:0]       db_ff, db_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RowW-1:0]         rsp_row_ff, rsp_row_in;
   logic signed [CoefW-1:0] rsp_lower_a_ff, rsp_lower_a_in, rsp_main_a_ff, rsp_main_a_in;
   logic signed [CoefW-1:0] rsp_upper_a_ff, rsp_upper_a_in, rsp_lower_b_ff, rsp_lower_b_in;
   logic signed [CoefW-1:0] rsp_main_b_ff, rsp_main_b_in, rsp_upper_b_ff, rsp_upper_b_in;
   logic                    rsp_sat_ff, rsp_sat_in, rsp_last_ff, rsp_last_in;

   logic                    rsp_free;
   logic                    finish;
   logic [CoordW-1:0]       finish_coord;
   logic                    finish_last;
   logic [CoordW-1:0]       div_va, div_vb;
   logic [CoordW:0]         div_v;
   logic [CoordW-1:0]       div_mag;
   logic [QuoW-1:0]         div_dividend;
   div_type                 div_one, div_two;
   logic                    div_wr;
   logic signed [CoefW-1:0] div_wr_val;
   logic signed [CoefW-1:0] op_a, op_b;
   logic                    op_neg_a, op_neg_b, op_is_mul;
   sat_val_type             add_a, add_b, add_sum, mul_res;
   logic                    res_wr;
   logic signed [CoefW-1:0] res_val;
   logic [HalfW-1:0]        mul_a_half, mul_b_half;
   row_type                 row_int, row_end;
   logic [CountW-1:0]       row_src;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;

   // divisor select
   always_comb begin
      case (div_idx_ff)
         DIV_SPAN: begin
            div_va = cur_ff;
            div_vb = older_ff;
         end
         DIV_INNER: begin
            div_va = prev_ff;
            div_vb = '0;
         end
         DIV_LEFT: begin
            div_va = prev_ff;
            div_vb = older_ff;
         end
         DIV_RIGHT: begin
            div_va = cur_ff;
            div_vb = prev_ff;
         end
         default: begin
            div_va = '0;
            div_vb = '0;
         end
      endcase
      div_v   = {1'b0, div_va} - {1'b0, div_vb};
      div_mag = div_v[CoordW] ? CoordW'(-div_v) : div_v[CoordW-1:0];
      if (div_idx_ff == DIV_LEFT || div_idx_ff == DIV_RIGHT) begin
         div_dividend = QuoW'(2) << RecipShift;
      end else begin
         div_dividend = QuoW'(1) << RecipShift;
      end
      div_one = div_step(div_ff, div_m_ff);
      div_two = div_step(div_one, div_m_ff);
   end

   // operand select for the add and multiply steps
   always_comb begin
      op_a      = '0;
      op_b      = '0;
      op_neg_a  = 1'b0;
      op_neg_b  = 1'b0;
      op_is_mul = 1'b0;
      case (seq_ff)
         SEQ_LO: begin
            op_a     = r2a_ff;
            op_b     = rx_ff;
            op_neg_b = 1'b1;
         end
         SEQ_UP: begin
            op_a = r2b_ff;
            op_b = rx_ff;
         end
         SEQ_C0: begin
            op_a      = rs_ff;
            op_b      = lo_ff;
            op_is_mul = 1'b1;
         end
         SEQ_C2: begin
            op_a      = rs_ff;
            op_b      = up_ff;
            op_is_mul = 1'b1;
         end
         SEQ_SA: begin
            op_a     = c0_ff;
            op_b     = c2_ff;
            op_neg_a = 1'b1;
            op_neg_b = 1'b1;
         end
         SEQ_MA: begin
            op_a     = tmp_ff;
            op_b     = signed'({1'b0, two_dt_ff});
            op_neg_b = 1'b1;
         end
         SEQ_C3: begin
            op_a      = signed'(CoefW'(db_ff));
            op_b      = c0_ff;
            op_is_mul = 1'b1;
         end
         SEQ_C5: begin
            op_a      = signed'(CoefW'(db_ff));
            op_b      = c2_ff;
            op_is_mul = 1'b1;
         end
         SEQ_SB: begin
            op_a     = c3_ff;
            op_b     = c5_ff;
            op_neg_a = 1'b1;
            op_neg_b = 1'b1;
         end
         SEQ_MB: begin
            op_a     = tmp_ff;
            op_b     = signed'({1'b0, two_dt_ff});
            op_neg_b = 1'b1;
         end
         default: begin
            op_a = '0;
         end
      endcase
      add_a   = op_neg_a ? sat_neg(op_a) : sat_val_type'({1'b0, op_a});
      add_b   = op_neg_b ? sat_neg(op_b) : sat_val_type'({1'b0, op_b});
      add_sum = sat_add(add_a.value, add_b.value);
   end

   assign mul_a_half = mul_cnt_ff[0] ? mul_a_ff[CoefW-1:HalfW] : mul_a_ff[HalfW-1:0];
   assign mul_b_half = mul_cnt_ff[1] ? mul_b_ff[CoefW-1:HalfW] : mul_b_ff[HalfW-1:0];

   always_comb begin
      if (|acc_ff[ProdW-1:CoefW+FracW]) begin
         mul_res.sat   = 1'b1;
         mul_res.value = mul_neg_ff ? COEF_MIN : COEF_MAX;
      end else begin
         mul_res = from_mag(acc_ff[CoefW+FracW-1:FracW], mul_neg_ff);
      end
   end

   assign row_src = start_ff ? '0 : points_ff - CountW'(1);
   assign row_int = row_clamp(row_src);
   assign row_end = row_clamp(points_ff);

   always_comb begin
      state_in       = state_ff;
      seq_in         = seq_ff;
      div_idx_in     = div_idx_ff;
      div_cnt_in     = div_cnt_ff;
      div_in         = div_ff;
      div_m_in       = div_m_ff;
      div_neg_in     = div_neg_ff;
      mul_a_in       = mul_a_ff;
      mul_b_in       = mul_b_ff;
      mul_neg_in     = mul_neg_ff;
      mul_cnt_in     = mul_cnt_ff;
      prod_in        = prod_ff;
      pp_sh_in       = pp_sh_ff;
      acc_in         = acc_ff;
      rs_in          = rs_ff;
      rx_in          = rx_ff;
      r2a_in         = r2a_ff;
      r2b_in         = r2b_ff;
      lo_in          = lo_ff;
      up_in          = up_ff;
      tmp_in         = tmp_ff;
      c0_in          = c0_ff;
      c2_in          = c2_ff;
      ma_in          = ma_ff;
      c3_in          = c3_ff;
      c5_in          = c5_ff;
      mb_in          = mb_ff;
      sat_in         = sat_ff;
      start_in       = start_ff;
      cur_in         = cur_ff;
      fin_in         = fin_ff;
      prev_in        = prev_ff;
      older_in       = older_ff;
      points_in      = points_ff;
      two_dt_in      = two_dt_ff;
      db_in          = db_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_row_in     = rsp_row_ff;
      rsp_lower_a_in = rsp_lower_a_ff;
      rsp_main_a_in  = rsp_main_a_ff;
      rsp_upper_a_in = rsp_upper_a_ff;
      rsp_lower_b_in = rsp_lower_b_ff;
      rsp_main_b_in  = rsp_main_b_ff;
      rsp_upper_b_in = rsp_upper_b_ff;
      rsp_sat_in     = rsp_sat_ff;
      rsp_last_in    = rsp_last_ff;
      finish         = 1'b0;
      finish_coord   = cur_ff;
      finish_last    = fin_ff;
      div_wr         = 1'b0;
      div_wr_val     = COEF_MAX;
      res_wr         = 1'b0;
      res_val        = add_sum.value;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cur_in   = req_coordinate;
               fin_in   = req_final_point;
               start_in = 1'b0;
               sat_in   = 1'b0;
               if (points_ff == '0 && !req_final_point) begin
                  start_in = 1'b1;
                  state_in = ST_OUT_ROW;
               end else if (points_ff >= CountW'(2)) begin
                  div_idx_in = DIV_SPAN;
                  state_in   = ST_DIV_START;
               end else if (req_final_point) begin
                  state_in = ST_OUT_END;
               end else begin
                  finish       = 1'b1;
                  finish_coord = req_coordinate;
                  finish_last  = req_final_point;
               end
            end
         end
         ST_DIV_START: begin
            if (div_v == '0) begin
               div_wr     = 1'b1;
               div_wr_val = COEF_MAX;
               sat_in     = 1'b1;
            end else begin
               div_in.rem = '0;
               div_in.quo = div_dividend;
               div_m_in   = div_mag;
               div_neg_in = div_v[CoordW];
               div_cnt_in = '0;
               state_in   = ST_DIV_RUN;
            end
         end
         ST_DIV_RUN: begin
            div_in     = div_two;
            div_cnt_in = div_cnt_ff + DivCntW'(1);
            if (div_cnt_ff == DivCntW'(DivCycles - 1)) begin
               div_wr     = 1'b1;
               div_wr_val = div_neg_ff ? CoefW'(0) - CoefW'(div_two.quo)
                                       : signed'(CoefW'(div_two.quo));
            end
         end
         ST_DISPATCH: begin
            if (seq_ff == SEQ_DONE) begin
               state_in = ST_OUT_ROW;
            end else if (op_is_mul) begin
               mul_a_in   = mag(op_a);
               mul_b_in   = mag(op_b);
               mul_neg_in = op_a[CoefW-1] ^ op_b[CoefW-1];
               mul_cnt_in = '0;
               acc_in     = '0;
               state_in   = ST_MUL_RUN;
            end else begin
               res_wr  = 1'b1;
               res_val = add_sum.value;
               sat_in  = sat_ff | add_a.sat | add_b.sat | add_sum.sat;
               seq_in  = seq_type'(seq_ff + 4'd1);
            end
         end
         ST_MUL_RUN: begin
            if (mul_cnt_ff < MulCntW'(MulSteps)) begin
               prod_in  = mul_a_half * mul_b_half;
               pp_sh_in = 2'(mul_cnt_ff[0]) + 2'(mul_cnt_ff[1]);
            end
            if (mul_cnt_ff != '0) begin
               acc_in = acc_ff + (ProdW'(prod_ff) << {pp_sh_ff, 5'd0});
            end
            mul_cnt_in = mul_cnt_ff + MulCntW'(1);
            if (mul_cnt_ff == MulCntW'(MulSteps)) begin
               state_in = ST_MUL_END;
            end
         end
         ST_MUL_END: begin
            res_wr   = 1'b1;
            res_val  = mul_res.value;
            sat_in   = sat_ff | mul_res.sat;
            seq_in   = seq_type'(seq_ff + 4'd1);
            state_in = ST_DISPATCH;
         end
         ST_OUT_ROW: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = row_int.row;
               rsp_last_in  = 1'b0;
               if (start_ff) begin
                  rsp_lower_a_in = '0;
                  rsp_main_a_in  = -ONE_Q24;
                  rsp_upper_a_in = ONE_Q24;
                  rsp_lower_b_in = '0;
                  rsp_main_b_in  = -ONE_Q24;
                  rsp_upper_b_in = ONE_Q24;
                  rsp_sat_in     = row_int.ovf;
               end else begin
                  rsp_lower_a_in = c0_ff;
                  rsp_main_a_in  = ma_ff;
                  rsp_upper_a_in = c2_ff;
                  rsp_lower_b_in = c3_ff;
                  rsp_main_b_in  = mb_ff;
                  rsp_upper_b_in = c5_ff;
                  rsp_sat_in     = sat_ff | row_int.ovf;
               end
               if (fin_ff) begin
                  state_in = ST_OUT_END;
               end else begin
                  finish   = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_OUT_END: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_row_in     = row_end.row;
               rsp_lower_a_in = '0;
               rsp_main_a_in  = ONE_Q24;
               rsp_upper_a_in = '0;
               rsp_lower_b_in = '0;
               rsp_main_b_in  = ONE_Q24;
               rsp_upper_b_in = '0;
               rsp_sat_in     = row_end.ovf;
               rsp_last_in    = 1'b1;
               finish         = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (div_wr) begin
         case (div_idx_ff)
            DIV_SPAN:  rs_in  = div_wr_val;
            DIV_INNER: rx_in  = div_wr_val;
            DIV_LEFT:  r2a_in = div_wr_val;
            DIV_RIGHT: r2b_in = div_wr_val;
            default:   rs_in  = div_wr_val;
         endcase
         if (div_idx_ff == DIV_RIGHT) begin
            seq_in   = SEQ_LO;
            state_in = ST_DISPATCH;
         end else begin
            div_idx_in = div_sel_type'(div_idx_ff + 2'd1);
            state_in   = ST_DIV_START;
         end
      end

      if (res_wr) begin
         case (seq_ff)
            SEQ_LO:  lo_in  = res_val;
            SEQ_UP:  up_in  = res_val;
            SEQ_C0:  c0_in  = res_val;
            SEQ_C2:  c2_in  = res_val;
            SEQ_SA:  tmp_in = res_val;
            SEQ_MA:  ma_in  = res_val;
            SEQ_C3:  c3_in  = res_val;
            SEQ_C5:  c5_in  = res_val;
            SEQ_SB:  tmp_in = res_val;
            SEQ_MB:  mb_in  = res_val;
            default: tmp_in = tmp_ff;
         endcase
      end

      // run state moves on once the point's rows are out
      if (finish) begin
         older_in = prev_ff;
         prev_in  = finish_coord;
         if (finish_last) begin
            points_in = '0;
         end else if (points_ff < CountW'(MaxPoints + 1)) begin
            points_in = points_ff + CountW'(1);
         end
      end

      if (csr_valid) begin
         case (csr_index)
            CSR_TWO_DT: two_dt_in = csr_wdata[TwoDtW-1:0];
            CSR_RATIO:  db_in     = csr_wdata[RatioW-1:0];
            default:    db_in     = db_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seq_ff       <= SEQ_LO;
         div_idx_ff   <= DIV_SPAN;
         div_cnt_ff   <= '0;
         mul_cnt_ff   <= '0;
         prev_ff      <= '0;
         older_ff     <= '0;
         points_ff    <= '0;
         two_dt_ff    <= TwoDtW'(64'd3355443200);
         db_ff        <= RatioW'(32'd16777216);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seq_ff       <= seq_in;
         div_idx_ff   <= div_idx_in;
         div_cnt_ff   <= div_cnt_in;
         mul_cnt_ff   <= mul_cnt_in;
         prev_ff      <= prev_in;
         older_ff     <= older_in;
         points_ff    <= points_in;
         two_dt_ff    <= two_dt_in;
         db_ff        <= db_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      div_ff         <= div_in;
      div_m_ff       <= div_m_in;
      div_neg_ff     <= div_neg_in;
      mul_a_ff       <= mul_a_in;
      mul_b_ff       <= mul_b_in;
      mul_neg_ff     <= mul_neg_in;
      prod_ff        <= prod_in;
      pp_sh_ff       <= pp_sh_in;
      acc_ff         <= acc_in;
      rs_ff          <= rs_in;
      rx_ff          <= rx_in;
      r2a_ff         <= r2a_in;
      r2b_ff         <= r2b_in;
      lo_ff          <= lo_in;
      up_ff          <= up_in;
      tmp_ff         <= tmp_in;
      c0_ff          <= c0_in;
      c2_ff          <= c2_in;
      ma_ff          <= ma_in;
      c3_ff          <= c3_in;
      c5_ff          <= c5_in;
      mb_ff          <= mb_in;
      sat_ff         <= sat_in;
      start_ff       <= start_in;
      cur_ff         <= cur_in;
      fin_ff         <= fin_in;
      rsp_row_ff     <= rsp_row_in;
      rsp_lower_a_ff <= rsp_lower_a_in;
      rsp_main_a_ff  <= rsp_main_a_in;
      rsp_upper_a_ff <= rsp_upper_a_in;
      rsp_lower_b_ff <= rsp_lower_b_in;
      rsp_main_b_ff  <= rsp_main_b_in;
      rsp_upper_b_ff <= rsp_upper_b_in;
      rsp_sat_ff     <= rsp_sat_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_row       = rsp_row_ff;
   assign rsp_lower_a   = rsp_lower_a_ff;
   assign rsp_main_a    = rsp_main_a_ff;
   assign rsp_upper_a   = rsp_upper_a_ff;
   assign rsp_lower_b   = rsp_lower_b_ff;
   assign rsp_main_b    = rsp_main_b_ff;
   assign rsp_upper_b   = rsp_upper_b_ff;
   assign rsp_saturated = rsp_sat_ff;
   assign rsp_last_row  = rsp_last_ff;

   a_div_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_RUN) |-> (div_ff.rem < div_m_ff))
      else $error("divider remainder not below divisor");

   a_mul_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL_RUN) |-> (mul_cnt_ff <= MulCntW'(MulSteps)))
      else $error("multiply pass count out of range");

   a_points_bound: assert property (@(posedge clock) disable iff (reset)
      points_ff <= CountW'(MaxPoints + 1))
      else $error("point count beyond saturation");

   a_end_row_closes_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT_END && rsp_free) |=> (state_ff == ST_IDLE && points_ff == '0))
      else $error("end row transfer did not close the run");

endmodule

// ===== verif/radial_tridiagonal_coefficients_core_tb.sv =====
module radial_tridiagonal_coefficients_core_tb;
   import rtc_pkg::*;

   localparam int SettleCycles = 200;
   localparam int TailCycles   = 200;
   localparam int HoldCycles   = 800;
   localparam int QuietLimit   = 10000;
   localparam int ReportLimit  = 200;

   typedef struct packed {
      logic [CoordW-1:0] coordinate;
      logic              final_point;
   } grid_point_t;

   typedef struct packed {
      logic [RowW-1:0]         row;
      logic signed [CoefW-1:0] lower_a, main_a, upper_a, lower_b, main_b, upper_b;
      logic                    saturated;
      logic                    last_row;
   } coef_row_t;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [CoordW-1:0]       req_coordinate = '0;
   logic                    req_final_point = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [RowW-1:0]         rsp_row;
   logic signed [CoefW-1:0] rsp_lower_a, rsp_main_a, rsp_upper_a;
   logic signed [CoefW-1:0] rsp_lower_b, rsp_main_b, rsp_upper_b;
   logic                    rsp_saturated;
   logic                    rsp_last_row;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CsrIndexW-1:0]    csr_index = '0;
   logic [CsrDataW-1:0]     csr_wdata = '0;

   grid_point_t pending_points[$];
   coef_row_t   expected_rows[$];
   grid_point_t offered;
   bit          in_flight = 1'b0;
   int          send_gap_pct = 0;
   int          recv_gap_pct = 0;
   bit          hold_request = 1'b0;
   int          hold_left = 0;
   int          quiet_cycles = 0;
   int          error_count = 0;

   // predictor state
   logic [TwoDtW-1:0] two_over_dt = 63'd3355443200;
   logic [RatioW-1:0] ratio_b = 32'd16777216;
   logic [CoordW-1:0] prev_coord = '0;
   logic [CoordW-1:0] older_coord = '0;
   logic [CountW-1:0] points_seen = '0;
   bit                row_flag;

   radial_tridiagonal_coefficients_core dut (.*);

   always #10 clock = ~clock;

   function automatic logic signed [CoefW-1:0] clip_sum(input logic signed [CoefW-1:0] a,
                                                        input logic signed [CoefW-1:0] b);
      logic signed [CoefW-1:0] s;
      s = a + b;
      if (!a[CoefW-1] && !b[CoefW-1] && s[CoefW-1]) begin
         row_flag = 1'b1;
         return COEF_MAX;
      end
      if (a[CoefW-1] && b[CoefW-1] && !s[CoefW-1]) begin
         row_flag = 1'b1;
         return COEF_MIN;
      end
      return s;
   endfunction

   function automatic logic signed [CoefW-1:0] clip_negate(input logic signed [CoefW-1:0] a);
      if (a == COEF_MIN) begin
         row_flag = 1'b1;
         return COEF_MAX;
      end
      return -a;
   endfunction

   function automatic logic [CoefW-1:0] abs_val(input logic signed [CoefW-1:0] a);
      return a[CoefW-1] ? -a : a;
   endfunction

   function automatic logic signed [CoefW-1:0] signed_from_abs(input logic [CoefW-1:0] m,
                                                               input logic neg);
      if (neg) begin
         if (m > {1'b1, {(CoefW-1){1'b0}}}) begin
            row_flag = 1'b1;
            return COEF_MIN;
         end
         return -m;
      end
      if (m[CoefW-1]) begin
         row_flag = 1'b1;
         return COEF_MAX;
      end
      return m;
   endfunction

   // n * 2^48 / v, magnitude truncated
   function automatic logic signed [CoefW-1:0] reciprocal(input logic [1:0] n,
                                                          input logic signed [CoefW-1:0] v);
      logic [CoefW-1:0] q;
      if (v == 0) begin
         row_flag = 1'b1;
         return COEF_MAX;
      end
      q = ({62'b0, n} << RecipShift) / abs_val(v);
      return signed_from_abs(q, v[CoefW-1]);
   endfunction

   function automatic logic signed [CoefW-1:0] q24_product(input logic signed [CoefW-1:0] a,
                                                           input logic signed [CoefW-1:0] b);
      logic [2*CoefW-1:0] p;
      logic               neg;
      p   = {64'b0, abs_val(a)} * {64'b0, abs_val(b)};
      neg = a[CoefW-1] ^ b[CoefW-1];
      if (p[2*CoefW-1:CoefW+FracW] != 0) begin
         row_flag = 1'b1;
         return neg ? COEF_MIN : COEF_MAX;
      end
      return signed_from_abs(p[CoefW+FracW-1:FracW], neg);
   endfunction

   function automatic void file_row(input coef_row_t r, input logic [CountW-1:0] index);
      if (index > CountW'(MaxPoints - 1)) begin
         r.row       = RowW'(MaxPoints - 1);
         r.saturated = 1'b1;
      end else begin
         r.row = RowW'(index);
      end
      expected_rows.push_back(r);
   endfunction

   function automatic void predict_point(input grid_point_t p);
      coef_row_t               r;
      logic [CountW-1:0]       k;
      logic signed [CoefW-1:0] x0, x1, x2, span_r, inner_r, lower_t, upper_t, two_dt, ratio;
      k = points_seen;
      if (k == 0 && !p.final_point) begin
         r = '{row: '0, lower_a: '0, main_a: -ONE_Q24, upper_a: ONE_Q24,
               lower_b: '0, main_b: -ONE_Q24, upper_b: ONE_Q24, saturated: 1'b0, last_row: 1'b0};
         file_row(r, '0);
      end else if (k >= 2) begin
         row_flag  = 1'b0;
         x0        = {32'b0, older_coord};
         x1        = {32'b0, prev_coord};
         x2        = {32'b0, p.coordinate};
         two_dt    = {1'b0, two_over_dt};
         ratio     = {32'b0, ratio_b};
         span_r    = reciprocal(2'd1, x2 - x0);
         inner_r   = reciprocal(2'd1, x1);
         lower_t   = clip_sum(reciprocal(2'd2, x1 - x0), clip_negate(inner_r));
         upper_t   = clip_sum(reciprocal(2'd2, x2 - x1), inner_r);
         r.lower_a = q24_product(span_r, lower_t);
         r.upper_a = q24_product(span_r, upper_t);
         r.main_a  = clip_sum(clip_sum(clip_negate(r.lower_a), clip_negate(r.upper_a)),
                              clip_negate(two_dt));
         r.lower_b = q24_product(ratio, r.lower_a);
         r.upper_b = q24_product(ratio, r.upper_a);
         r.main_b  = clip_sum(clip_sum(clip_negate(r.lower_b), clip_negate(r.upper_b)),
                              clip_negate(two_dt));
         r.row       = '0;
         r.saturated = row_flag;
         r.last_row  = 1'b0;
         file_row(r, k - 1'b1);
      end
      if (p.final_point) begin
         r = '{row: '0, lower_a: '0, main_a: ONE_Q24, upper_a: '0,
               lower_b: '0, main_b: ONE_Q24, upper_b: '0, saturated: 1'b0, last_row: 1'b1};
         file_row(r, k);
      end
      older_coord = prev_coord;
      prev_coord  = p.coordinate;
      if (p.final_point) points_seen = '0;
      else if (points_seen < CountW'(MaxPoints + 1)) points_seen = points_seen + 1'b1;
   endfunction

   function automatic void compare_field(input string name, input logic [CoefW-1:0] want,
                                         input logic [CoefW-1:0] got);
      if (want !== got) begin
         error_count++;
         if (error_count <= ReportLimit)
            $error("%s: expected %h, got %h", name, want, got);
      end
   endfunction

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            predict_point(offered);
            in_flight = 1'b0;
         end
         if (!in_flight && pending_points.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
            offered   = pending_points.pop_front();
            in_flight = 1'b1;
            req_coordinate  <= offered.coordinate;
            req_final_point <= offered.final_point;
         end
         req_valid <= in_flight;
      end
   end

   // monitor
   always @(posedge clock) begin : rsp_monitor
      coef_row_t want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rows.size() == 0) begin
               error_count++;
               $error("row %0d transferred with nothing expected", rsp_row);
            end else begin
               want = expected_rows.pop_front();
               compare_field("row", want.row, rsp_row);
               compare_field("lower_a", want.lower_a, rsp_lower_a);
               compare_field("main_a", want.main_a, rsp_main_a);
               compare_field("upper_a", want.upper_a, rsp_upper_a);
               compare_field("lower_b", want.lower_b, rsp_lower_b);
               compare_field("main_b", want.main_b, rsp_main_b);
               compare_field("upper_b", want.upper_b, rsp_upper_b);
               compare_field("saturated", want.saturated, rsp_saturated);
               compare_field("last_row", want.last_row, rsp_last_row);
            end
         end
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HoldCycles;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_gap_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QuietLimit) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic wait_drained();
      while (pending_points.size() != 0 || in_flight || expected_rows.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_reg(input logic [CsrIndexW-1:0] index, input logic [CsrDataW-1:0] data);
      wait_drained();
      repeat (SettleCycles) @(posedge clock);
      csr_index <= index;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      if (index == CSR_TWO_DT) two_over_dt = data[TwoDtW-1:0];
      else ratio_b = data[RatioW-1:0];
      csr_valid <= 1'b0;
   endtask

   task automatic push_point(input logic [CoordW-1:0] coordinate, input logic final_point);
      pending_points.push_back('{coordinate: coordinate, final_point: final_point});
   endtask

   // orderly: strictly increasing run ending in a final point; otherwise junk with stray finals
   task automatic queue_run(input int count, input bit orderly);
      logic [CoordW-1:0] step_max, coord;
      logic [63:0]       reach;
      int                i;
      coord = $urandom();
      if (orderly) begin
         case ($urandom_range(2))
            0: step_max = 255;
            1: step_max = 65535;
            default: step_max = 32'hFFFF_FFFF / count;
         endcase
         reach = 64'(step_max) * count;
         if (reach > 64'hFFFF_FFFF) begin
            step_max = 32'hFFFF_FFFF / count;
            reach    = 64'(step_max) * count;
         end
         coord = $urandom_range(32'hFFFF_FFFF - reach[31:0], 0);
         for (i = 0; i < count; i++) begin
            push_point(coord, i == count - 1);
            coord = coord + $urandom_range(step_max, 1);
         end
      end else begin
         for (i = 0; i < count; i++) begin
            if ($urandom_range(3) != 0) coord = $urandom();
            push_point(coord, (i == count - 1) || ($urandom_range(3) == 0));
         end
      end
   endtask

   task automatic run_batch(input int items);
      int queued, n;
      queued = 0;
      while (queued < items) begin
         if ($urandom_range(9) < 8) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
            queue_run(n, 1'b1);
         end else begin
            n = $urandom_range(8, 1);
            queue_run(n, 1'b0);
         end
         queued += n;
      end
      wait_drained();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      send_gap_pct = 29;
      recv_gap_pct = 51;

      push_point(32'h0000_0000, 1'b1);
      push_point(32'h0100_0000, 1'b0);
      push_point(32'h0200_0000, 1'b1);
      // coincident points and a zero radius
      push_point(32'h0000_0000, 1'b0);
      push_point(32'h0000_0000, 1'b0);
      push_point(32'h0000_0000, 1'b0);
      push_point(32'h0000_0005, 1'b1);
      push_point(32'hFFFF_FFFF, 1'b0);
      push_point(32'h8000_0000, 1'b0);
      push_point(32'h0000_0001, 1'b0);
      push_point(32'hFFFF_FFFF, 1'b1);
      push_point(32'h0100_0000, 1'b0);
      push_point(32'h0180_0000, 1'b0);
      push_point(32'h0200_0000, 1'b0);
      push_point(32'h0300_0000, 1'b1);
      push_point(32'h0000_0010, 1'b0);
      push_point(32'h0000_0011, 1'b0);
      push_point(32'h0000_0012, 1'b1);
      wait_drained();

      write_reg(CSR_TWO_DT, 64'h7FFF_FFFF_FFFF_FFFF);
      write_reg(CSR_RATIO, 64'hFFFF_FFFF);
      run_batch(100);
      write_reg(CSR_TWO_DT, '0);
      write_reg(CSR_RATIO, '0);
      run_batch(100);

      send_gap_pct = 51;
      recv_gap_pct = 29;
      write_reg(CSR_TWO_DT, 64'd3355443200);
      write_reg(CSR_RATIO, 64'h0080_0000);
      run_batch(100);
      write_reg(CSR_TWO_DT, {20'b0, 12'($urandom()), 32'($urandom())});
      write_reg(CSR_RATIO, {32'b0, 32'($urandom())});
      run_batch(100);

      send_gap_pct = 0;
      recv_gap_pct = 0;
      write_reg(CSR_TWO_DT, {32'($urandom()), 32'($urandom())});
      write_reg(CSR_RATIO, {32'($urandom()), 32'($urandom())});
      hold_request = 1'b1;
      run_batch(80);
      // long run drives the row index past the matrix size
      write_reg(CSR_TWO_DT, 64'd3355443200);
      write_reg(CSR_RATIO, 64'h0100_0000);
      queue_run(MaxPoints + 4, 1'b1);
      wait_drained();
      write_reg(CSR_TWO_DT, {20'b0, 12'($urandom()), 32'($urandom())});
      write_reg(CSR_RATIO, {32'b0, 32'($urandom())});
      run_batch(40);

      repeat (TailCycles) @(posedge clock);
      if (expected_rows.size() != 0) begin
         error_count++;
         $error("%0d expected rows never arrived", expected_rows.size());
      end
      if (error_count == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/rtc_pkg.sv
rtl/core/radial_tridiagonal_coefficients_core.sv
verif/radial_tridiagonal_coefficients_core_tb.sv
